>>> rtl/core/ldwp_pkg.sv
// ----------------------------------------------------------------------------
// ldwp_pkg
// Shared sizes, register indexes and reset values of the least-deficit picker.
// ----------------------------------------------------------------------------
package ldwp_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int DATA_W    = 64;
  localparam int PERIOD_W  = 63;
  localparam int WCNT_W    = 8;
  localparam int WID_W     = 3;
  localparam int CFG_IDX_W = 4;

  localparam logic [SLOT_W-1:0] SLOT_LAST     = SLOT_W'(NUM_SLOTS - 1);
  localparam logic [WCNT_W-1:0] SLOT_LAST_CNT = WCNT_W'(NUM_SLOTS - 1);

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_WORKER_COUNT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_THRESHOLD = CFG_IDX_W'(1);

  localparam logic [WCNT_W-1:0] WORKER_COUNT_RST    = WCNT_W'(8);
  localparam logic [DATA_W-1:0] DECAY_THRESHOLD_RST = DATA_W'(1000000);

  // Fewer workers than this leave no slot to scan.
  localparam logic [WCNT_W-1:0] MIN_SCAN_WORKERS = WCNT_W'(3);
  localparam logic [WCNT_W-1:0] RESERVED_WORKERS = WCNT_W'(2);

  // Constant divider: quotient bits resolved per cycle, and the two divisors.
  localparam int DIV_BITS_PER_CYCLE = 8;
  localparam int DIV_CYCLES         = DATA_W / DIV_BITS_PER_CYCLE;
  localparam int DIV_CNT_W          = $clog2(DIV_CYCLES);
  localparam int REM_W              = 10;
  localparam logic [REM_W-1:0] DIVISOR_IO     = REM_W'(100);
  localparam logic [REM_W-1:0] DIVISOR_PERIOD = REM_W'(1000);

  localparam logic [DATA_W-1:0] COST_MIN = DATA_W'(1);

endpackage

>>> rtl/core/ldwp_ram.sv
// ----------------------------------------------------------------------------
// ldwp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ldwp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/least_deficit_worker_picker_top.sv
// ----------------------------------------------------------------------------
// least_deficit_worker_picker_top
// Picks the eligible worker slot with the smallest deficit and charges it.
// ----------------------------------------------------------------------------
// Usage. Each request beat on req_* carries one task. The block answers with
// exactly one response beat on rsp_* naming the chosen worker slot, or worker
// 0 with fell_back set when the task is missing or no slot can be chosen.
// Both channels are valid/stall: a beat moves when valid is high and stall is
// low. The configuration channel (cfg_valid/cfg_ready, always ready) writes
// worker_count and decay_threshold. The user must use it only while the block
// is idle; the block itself does not enforce this.
//
// Timing. One task is in flight at a time; req_stall is high from acceptance
// until the result is placed in the response register. The shared constant
// divider resolves 8 quotient bits a cycle while the deficit scan runs
// alongside it out of the deficit RAM. If the scanned minimum is above
// decay_threshold, a halving sweep follows, one RAM entry a cycle. A missing
// task skips the divider and the scan and goes straight to the response.
//
// Reset clears the per-slot valid bits, so every deficit reads as zero; no
// clearing pass is needed. If the receiver stalls, the finished result waits
// in the response register and the next request is accepted meanwhile.
// ----------------------------------------------------------------------------
module least_deficit_worker_picker_top (
  input  logic                           clk,
  input  logic                           rst,
  // Request channel.
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic                           task_missing,
  input  logic                           has_stats,
  input  logic [ldwp_pkg::DATA_W-1:0]    io_bytes,
  input  logic [ldwp_pkg::DATA_W-1:0]    compute_us,
  input  logic [ldwp_pkg::PERIOD_W-1:0]  task_period,
  // Response channel.
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic [ldwp_pkg::WID_W-1:0]     slot_id,
  output logic                           fell_back,
  // Configuration write channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ldwp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ldwp_pkg::DATA_W-1:0]    cfg_data
);

  import ldwp_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_WORK   = 3'd1;
  localparam logic [2:0] ST_HALVE  = 3'd2;
  localparam logic [2:0] ST_UPD_RD = 3'd3;
  localparam logic [2:0] ST_UPD_WR = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0] state;

  // Configuration registers.
  logic [WCNT_W-1:0] worker_count;
  logic [DATA_W-1:0] decay_threshold;

  // Task operands and the iterative constant divider.
  logic                 has_stats_q;
  logic [DATA_W-1:0]    compute_us_q;
  logic                 period_zero;
  logic [DATA_W-1:0]    div_q;
  logic [REM_W-1:0]     div_rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 div_busy;
  logic [DATA_W-1:0]    div_q_next;
  logic [REM_W-1:0]     div_rem_next;
  logic [DATA_W-1:0]    cost;
  logic [DATA_W-1:0]    cost_next;
  logic [DATA_W-1:0]    stats_sum;

  // Scan, sweep and the one-deep read pipeline of the deficit RAM.
  logic [SLOT_W-1:0]    scan_addr;
  logic [SLOT_W-1:0]    scan_last;
  logic                 scan_more;
  logic [SLOT_W-1:0]    scan_last_next;
  logic                 scan_any;
  logic [WCNT_W-1:0]    wc_minus;
  logic [SLOT_W-1:0]    sweep_addr;
  logic                 sweep_more;
  logic                 rd_en;
  logic [SLOT_W-1:0]    rd_addr;
  logic                 rd_pend;
  logic [SLOT_W-1:0]    rd_idx;
  logic [DATA_W-1:0]    rd_data;
  logic [DATA_W-1:0]    rd_eff;
  logic                 mem_we;
  logic [SLOT_W-1:0]    mem_waddr;
  logic [DATA_W-1:0]    mem_wdata;
  logic [NUM_SLOTS-1:0] valid_bits;

  // Scan result.
  logic [DATA_W-1:0]    lowest;
  logic [SLOT_W-1:0]    pick;
  logic                 found;

  logic work_done;
  logic take_min;
  logic rsp_free;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != ST_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // Slots 1 .. worker_count-2, clamped to the last slot of the RAM.
  assign wc_minus = worker_count - RESERVED_WORKERS;
  assign scan_any = (worker_count >= MIN_SCAN_WORKERS);
  assign scan_last_next = (wc_minus >= SLOT_LAST_CNT) ? SLOT_LAST : wc_minus[SLOT_W-1:0];

  // A slot never written since reset holds a deficit of zero.
  assign rd_eff   = valid_bits[rd_idx] ? rd_data : '0;
  assign take_min = (state == ST_WORK) && rd_pend && (rd_eff < lowest);
  assign work_done = !div_busy && !scan_more && !rd_pend;

  // Eight restoring steps of division by 100 or 1000 per cycle. The dividend
  // shifts out of the top of div_q while quotient bits enter at the bottom.
  always_comb begin
    logic [DATA_W-1:0] dq;
    logic [REM_W-1:0]  dr;
    logic [REM_W:0]    trial;
    logic [REM_W-1:0]  dvs;
    dvs = has_stats_q ? DIVISOR_IO : DIVISOR_PERIOD;
    dq  = div_q;
    dr  = div_rem;
    for (int s = 0; s < DIV_BITS_PER_CYCLE; s++) begin
      trial = {dr, dq[DATA_W-1]};
      dq    = {dq[DATA_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        trial = trial - {1'b0, dvs};
        dq[0] = 1'b1;
      end
      dr = trial[REM_W-1:0];
    end
    div_q_next   = dq;
    div_rem_next = dr;
  end

  assign stats_sum = div_q + compute_us_q;
  always_comb begin
    if (has_stats_q) begin
      cost_next = (stats_sum == '0) ? COST_MIN : stats_sum;
    end else begin
      cost_next = period_zero ? COST_MIN : div_q;
    end
  end

  // RAM port control.
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = scan_addr;
    mem_we    = 1'b0;
    mem_waddr = rd_idx;
    mem_wdata = rd_eff >> 1;
    unique case (state)
      ST_WORK: begin
        rd_en   = scan_more;
        rd_addr = scan_addr;
      end
      ST_HALVE: begin
        rd_en   = sweep_more;
        rd_addr = sweep_addr;
        mem_we  = rd_pend;
      end
      ST_UPD_RD: begin
        rd_en   = 1'b1;
        rd_addr = pick;
      end
      ST_UPD_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pick;
        mem_wdata = rd_eff + cost;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  ldwp_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NUM_SLOTS)
  ) u_deficit_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      worker_count    <= WORKER_COUNT_RST;
      decay_threshold <= DECAY_THRESHOLD_RST;
      div_busy        <= 1'b0;
      div_cnt         <= '0;
      scan_more       <= 1'b0;
      sweep_more      <= 1'b0;
      rd_pend         <= 1'b0;
      found           <= 1'b0;
      valid_bits      <= '0;
      rsp_valid       <= 1'b0;
    end else begin
      rd_pend <= rd_en;

      if (cfg_valid && cfg_ready) begin
        priority if (cfg_index == REG_WORKER_COUNT) begin
          worker_count <= cfg_data[WCNT_W-1:0];
        end else if (cfg_index == REG_DECAY_THRESHOLD) begin
          decay_threshold <= cfg_data;
        end
      end

      // A finished result enters the response register once it is free; a
      // beat that moves without a successor behind it empties the register.
      if ((state == ST_DONE) && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            found <= 1'b0;
            if (task_missing) begin
              state <= ST_DONE;
            end else begin
              div_busy  <= 1'b1;
              div_cnt   <= '0;
              scan_more <= scan_any;
              state     <= ST_WORK;
            end
          end
        end
        ST_WORK: begin
          if (div_busy) begin
            div_cnt <= div_cnt + 1'b1;
            if (div_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
              div_busy <= 1'b0;
            end
          end
          if (scan_more && (scan_addr == scan_last)) begin
            scan_more <= 1'b0;
          end
          if (take_min) begin
            found <= 1'b1;
          end
          if (work_done) begin
            priority if (lowest > decay_threshold) begin
              sweep_more <= 1'b1;
              state      <= ST_HALVE;
            end else if (found) begin
              state <= ST_UPD_RD;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_HALVE: begin
          if (sweep_more && (sweep_addr == SLOT_LAST)) begin
            sweep_more <= 1'b0;
          end
          if (rd_pend) begin
            valid_bits[rd_idx] <= 1'b1;
          end
          if (!sweep_more && !rd_pend) begin
            state <= found ? ST_UPD_RD : ST_DONE;
          end
        end
        ST_UPD_RD: begin
          state <= ST_UPD_WR;
        end
        ST_UPD_WR: begin
          valid_bits[pick] <= 1'b1;
          state            <= ST_DONE;
        end
        ST_DONE: begin
          if (rsp_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers; these need no reset.
  always_ff @(posedge clk) begin
    rd_idx <= rd_addr;
    unique case (state)
      ST_IDLE: begin
        has_stats_q  <= has_stats;
        compute_us_q <= compute_us;
        period_zero  <= (task_period == '0);
        div_q        <= has_stats ? io_bytes : {1'b0, task_period};
        div_rem      <= '0;
        scan_addr    <= SLOT_W'(1);
        scan_last    <= scan_last_next;
        lowest       <= '1;
        pick         <= '0;
      end
      ST_WORK: begin
        if (div_busy) begin
          div_q   <= div_q_next;
          div_rem <= div_rem_next;
        end
        if (scan_more) begin
          scan_addr <= scan_addr + 1'b1;
        end
        if (take_min) begin
          lowest <= rd_eff;
          pick   <= rd_idx;
        end
        if (work_done) begin
          cost       <= cost_next;
          sweep_addr <= '0;
        end
      end
      ST_HALVE: begin
        if (sweep_more) begin
          sweep_addr <= sweep_addr + 1'b1;
        end
      end
      ST_DONE: begin
        if (rsp_free) begin
          slot_id   <= found ? WID_W'(pick) : '0;
          fell_back <= !found;
        end
      end
      default: begin
        cost <= cost;
      end
    endcase
  end

endmodule

>>> rtl/core/ldwp_checker.sv
// ----------------------------------------------------------------------------
// ldwp_checker
// Port-level checks of the least-deficit picker, bound to its top level.
// ----------------------------------------------------------------------------
module ldwp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_stall,
  input logic                           rsp_valid,
  input logic                           rsp_stall,
  input logic [ldwp_pkg::WID_W-1:0]     slot_id,
  input logic                           fell_back,
  input logic                           cfg_ready
);

  import ldwp_pkg::*;

  // Reset leaves no response pending.
  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid right after reset");

  // One task at a time: an accepted request closes the request side.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request accepted while a task is in flight");

  // A fallback response always names worker 0.
  a_fallback_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && fell_back) |-> (slot_id == '0))
    else $error("fallback response with nonzero worker");

  // A stalled response beat holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(slot_id) && $stable(fell_back)))
    else $error("stalled response changed");

  // The configuration channel never back-pressures.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration channel not ready");

endmodule

bind least_deficit_worker_picker_top ldwp_checker u_ldwp_checker (.*);

>>> sim/tb_least_deficit_worker_picker_top.sv
// ----------------------------------------------------------------------------
// tb_least_deficit_worker_picker_top
// Self-checking bench for the least-deficit worker picker.
// A software copy of the deficit table predicts the slot chosen for every
// accepted task beat. Each response beat is compared against the oldest
// prediction. A directed pass covers cost corners, saturation, halving and
// small worker counts. Random tasks then follow under three idle patterns.
// ----------------------------------------------------------------------------
module tb_least_deficit_worker_picker_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ldwp_pkg::*;

  localparam int CLK_HALF   = 5;
  localparam int RST_CYCLES = 7;
  localparam int TAIL_WAIT  = 40;
  localparam int CHUNK_JOBS = 50;
  localparam int CHUNKS     = 5;

  // Divisors of the two cost formulas.
  localparam logic [DATA_W-1:0] IO_BYTES_PER_UNIT = DATA_W'(100);
  localparam logic [DATA_W-1:0] NS_PER_UNIT       = DATA_W'(1000);

  // Lowest index on the configuration port that maps to no register.
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_DECAY_THRESHOLD + 1'b1;

  // One task request as it is driven onto the request channel.
  typedef struct {
    logic                missing;
    logic                stats;
    logic [DATA_W-1:0]   io;
    logic [DATA_W-1:0]   cu;
    logic [PERIOD_W-1:0] period;
  } job_t;

  // One predicted response.
  typedef struct {
    logic [WID_W-1:0] wid;
    logic             fb;
  } pick_t;

  typedef struct {
    logic [CFG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    data;
  } reg_write_t;

  // The ledger mirrors the block's deficit table and registers. It turns each
  // accepted task into the pick that the block should answer with, and keeps
  // those picks in order until the response beats arrive.
  class deficit_ledger;
    logic [WCNT_W-1:0] workers;
    logic [DATA_W-1:0] threshold;
    logic [DATA_W-1:0] deficit [NUM_SLOTS];
    pick_t             picks [$];
    int                errors;

    function new();
      workers   = WORKER_COUNT_RST;
      threshold = DECAY_THRESHOLD_RST;
      foreach (deficit[k]) deficit[k] = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      if (idx == REG_WORKER_COUNT) begin
        workers = data[WCNT_W-1:0];
      end else if (idx == REG_DECAY_THRESHOLD) begin
        threshold = data;
      end
    endfunction

    function logic [DATA_W-1:0] job_cost(job_t j);
      logic [DATA_W-1:0] c;
      c = COST_MIN;
      if (j.stats) begin
        c = j.io / IO_BYTES_PER_UNIT + j.cu;
        if (c == '0) c = COST_MIN;
      end else if (j.period != '0) begin
        // A period under one microsecond costs nothing.
        c = DATA_W'(j.period) / NS_PER_UNIT;
      end
      return c;
    endfunction

    function void charge_job(job_t j);
      logic [DATA_W-1:0] cost;
      logic [DATA_W-1:0] lowest;
      logic              found;
      int                pick;
      pick_t             p;
      if (j.missing) begin
        p.wid = '0;
        p.fb  = 1'b1;
        picks.insert(picks.size(), p);
        return;
      end
      cost   = job_cost(j);
      lowest = '1;
      found  = 1'b0;
      pick   = 0;
      // Slot 0 and the top worker are reserved; a saturated slot never wins.
      for (int s = 1; s < NUM_SLOTS; s++) begin
        if (s + 1 < int'(workers) && deficit[s] < lowest) begin
          lowest = deficit[s];
          pick   = s;
          found  = 1'b1;
        end
      end
      // Halving comes before the charge, and also happens with nothing found.
      if (lowest > threshold) begin
        foreach (deficit[k]) deficit[k] = deficit[k] >> 1;
      end
      if (found) begin
        deficit[pick] = deficit[pick] + cost;
        p.wid = WID_W'(pick);
        p.fb  = 1'b0;
      end else begin
        p.wid = '0;
        p.fb  = 1'b1;
      end
      picks.insert(picks.size(), p);
    endfunction

    function void match_pick(logic [WID_W-1:0] wid, logic fb);
      pick_t p;
      if (picks.size() == 0) begin
        $error("response beat with no pick pending: slot_id %0d fell_back %0b", wid, fb);
        errors++;
        return;
      end
      p = picks.pop_front();
      if (wid !== p.wid) begin
        $error("slot_id mismatch: expected %0d, actual %0d", p.wid, wid);
        errors++;
      end
      if (fb !== p.fb) begin
        $error("fell_back mismatch: expected %0b, actual %0b", p.fb, fb);
        errors++;
      end
    endfunction

    function int pending();
      return picks.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block inputs start at known values so nothing floats before reset ends.
  // --------------------------------------------------------------------------
  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 req_valid    = 1'b0;
  logic                 req_stall;
  logic                 task_missing = 1'b0;
  logic                 has_stats    = 1'b0;
  logic [DATA_W-1:0]    io_bytes     = '0;
  logic [DATA_W-1:0]    compute_us   = '0;
  logic [PERIOD_W-1:0]  task_period  = '0;
  logic                 rsp_valid;
  logic                 rsp_stall    = 1'b0;
  logic [WID_W-1:0]     slot_id;
  logic                 fell_back;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [DATA_W-1:0]    cfg_data     = '0;

  // Percent chance of an idle cycle on each side. The sender inserts gaps
  // before a beat; the receiver raises stall on a per-cycle coin flip.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  deficit_ledger ledger = new();
  reg_write_t    reg_plan [$];

  least_deficit_worker_picker_top u_top (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .task_missing (task_missing),
    .has_stats    (has_stats),
    .io_bytes     (io_bytes),
    .compute_us   (compute_us),
    .task_period  (task_period),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .slot_id      (slot_id),
    .fell_back    (fell_back),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // Response side. Outputs are read right after the edge, so they still hold
  // the values that the edge sampled. A beat moves when valid was high and our
  // own stall was low; the new stall for the next cycle is then chosen.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      ledger.match_pick(slot_id, fell_back);
    end
    rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  function automatic job_t mk_job(logic missing, logic stats, logic [DATA_W-1:0] io,
                                  logic [DATA_W-1:0] cu, logic [PERIOD_W-1:0] period);
    job_t j;
    j.missing = missing;
    j.stats   = stats;
    j.io      = io;
    j.cu      = cu;
    j.period  = period;
    return j;
  endfunction

  // Mostly small values so that deficits stay comparable, with zero, all ones
  // and full-width random values mixed in so every bit toggles.
  function automatic logic [DATA_W-1:0] rand_wide();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return {$urandom, $urandom};
      default: return DATA_W'($urandom_range(0, 5000));
    endcase
  endfunction

  function automatic job_t rand_job();
    job_t j;
    j.missing = ($urandom_range(0, 19) == 0);
    j.stats   = 1'($urandom_range(0, 1));
    j.io      = rand_wide();
    j.cu      = rand_wide();
    j.period  = PERIOD_W'(rand_wide());
    return j;
  endfunction

  function automatic logic [WCNT_W-1:0] rand_workers();
    case ($urandom_range(0, 9))
      0:       return WCNT_W'($urandom_range(0, 2));
      1:       return WCNT_W'($urandom_range(9, 255));
      default: return WCNT_W'($urandom_range(3, 8));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_threshold();
    case ($urandom_range(0, 9))
      0:          return '0;
      1:          return '1;
      2, 3, 4:    return DATA_W'($urandom_range(0, 64));
      5, 6, 7:    return DATA_W'($urandom_range(0, 2000000));
      default:    return {$urandom, $urandom};
    endcase
  endfunction

  // Sends one task beat, holding it steady until the block takes it. A gap,
  // if one is drawn, lowers valid in the step where the previous beat moved,
  // so valid is never lowered and raised within the same step.
  task automatic send_job(input job_t j);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    req_valid    <= 1'b1;
    task_missing <= j.missing;
    has_stats    <= j.stats;
    io_bytes     <= j.io;
    compute_us   <= j.cu;
    task_period  <= j.period;
    do @(posedge clk); while (req_stall);
    ledger.charge_job(j);
  endtask

  // Stops sending and waits until every predicted pick has been answered.
  // Every task yields a response, so the block is idle at that point.
  task automatic drain_picks();
    req_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  // Writes both registers while the block is idle. The worker count carries
  // random upper data bits, which the register must drop. Optionally a write
  // to an unmapped index goes first; it must change nothing.
  task automatic configure(input logic [WCNT_W-1:0] workers,
                           input logic [DATA_W-1:0] threshold, input logic add_spare);
    reg_write_t w;
    if (add_spare) begin
      w.idx  = REG_FIRST_UNUSED +
               CFG_IDX_W'($urandom_range(0, (1 << CFG_IDX_W) - 1 - REG_FIRST_UNUSED));
      w.data = {$urandom, $urandom};
      reg_plan.insert(reg_plan.size(), w);
    end
    w.idx  = REG_WORKER_COUNT;
    w.data = {$urandom, $urandom};
    w.data[WCNT_W-1:0] = workers;
    reg_plan.insert(reg_plan.size(), w);
    w.idx  = REG_DECAY_THRESHOLD;
    w.data = threshold;
    reg_plan.insert(reg_plan.size(), w);

    drain_picks();
    // Consecutive write beats keep valid high; it drops after the last one.
    while (reg_plan.size() != 0) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_plan[0].idx;
      cfg_data  <= reg_plan[0].data;
      do @(posedge clk); while (!cfg_ready);
      ledger.write_reg(reg_plan[0].idx, reg_plan[0].data);
      void'(reg_plan.pop_front());
    end
    cfg_valid <= 1'b0;
  endtask

  // A hung handshake ends here; a correct run needs well under a tenth of this.
  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 9;
    recv_idle_pct = 53;

    // With the threshold at all ones no halving can happen, so six tasks of
    // maximum cost saturate every eligible slot of the default eight workers.
    // A missing task is thrown in first with every other field at all ones.
    configure(WORKER_COUNT_RST, '1, 1'b0);
    send_job(mk_job(1'b1, 1'b1, '1, '1, '1));
    repeat (6) send_job(mk_job(1'b0, 1'b1, '0, '1, '0));
    // All eligible slots saturated: fallback, and the threshold blocks halving.
    send_job(mk_job(1'b0, 1'b0, '0, '0, '1));

    // Threshold zero: the saturated minimum now halves the table, then falls
    // back; the next task finds slots again after another halving.
    configure(WORKER_COUNT_RST, '0, 1'b0);
    send_job(mk_job(1'b0, 1'b1, '0, '0, '0));
    send_job(mk_job(1'b0, 1'b1, DATA_W'(99), '0, '0));

    // A single eligible slot, charged with each cost corner: zero period,
    // a period just under one unit, the widest period, wrapping sums and the
    // widest I/O count alone.
    configure(MIN_SCAN_WORKERS, DECAY_THRESHOLD_RST, 1'b0);
    send_job(mk_job(1'b0, 1'b0, '1, '1, '0));
    send_job(mk_job(1'b0, 1'b0, '0, '0, PERIOD_W'(999)));
    send_job(mk_job(1'b0, 1'b0, '0, '0, '1));
    send_job(mk_job(1'b0, 1'b1, '1, '1, '0));
    send_job(mk_job(1'b0, 1'b1, '1, '0, '0));

    // Too few workers to scan anything, down to a count of zero.
    configure(RESERVED_WORKERS, DECAY_THRESHOLD_RST, 1'b0);
    send_job(mk_job(1'b0, 1'b1, DATA_W'(500), DATA_W'(3), '0));
    configure(WCNT_W'(1), DECAY_THRESHOLD_RST, 1'b0);
    send_job(mk_job(1'b0, 1'b0, '0, '0, PERIOD_W'(4000)));
    configure('0, DECAY_THRESHOLD_RST, 1'b0);
    send_job(mk_job(1'b0, 1'b0, '0, '0, PERIOD_W'(1000)));

    // The largest count, clipped by the slot table, with an unmapped write.
    configure('1, DECAY_THRESHOLD_RST, 1'b1);
    send_job(mk_job(1'b0, 1'b1, DATA_W'(100), '0, '0));
    send_job(mk_job(1'b0, 1'b1, '0, DATA_W'(2), '0));
    configure(WCNT_W'(NUM_SLOTS + 1), DECAY_THRESHOLD_RST, 1'b0);
    send_job(mk_job(1'b0, 1'b0, '0, '0, PERIOD_W'(7000)));

    // Random tasks: three idle patterns, each split into chunks that run
    // under a freshly drawn worker count and threshold.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct = 53;
        end
        1: begin
          send_idle_pct = 53;
          recv_idle_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int ch = 0; ch < CHUNKS; ch++) begin
        configure(rand_workers(), rand_threshold(), ($urandom_range(0, 3) == 0));
        repeat (CHUNK_JOBS) send_job(rand_job());
      end
    end

    // Everything must come back, and nothing extra may follow.
    drain_picks();
    repeat (TAIL_WAIT) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
